@@ hw/rtl/hwf_pkg.sv @@
package hwf_pkg;

  localparam int DEFAULT_BINS = 1024;

  localparam int PADDR_W  = 4;
  localparam int APB_DW   = 32;

  localparam int X_W      = 16;
  localparam int CNT_W    = 11;
  localparam int RECIP_W  = 24;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int BIDX_W   = 10;
  localparam int VAL_W    = 48;
  localparam int ENT_W    = 32;
  localparam int ENTRY_W  = VAL_W + ENT_W;
  localparam int PROD_W   = X_W + RECIP_W;
  localparam int BIN_W    = PROD_W - FRAC_W;

  localparam logic [X_W-1:0]     X_MIN_RST       = 16'd0;
  localparam logic [X_W-1:0]     X_MAX_RST       = 16'd65535;
  localparam logic [CNT_W-1:0]   BIN_COUNT_RST   = 11'd1024;
  localparam logic [RECIP_W-1:0] WIDTH_RECIP_RST = 24'd1024;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [ENT_W-1:0]        ENT_MAX = '1;

  typedef enum logic [1:0] {
    REG_X_MIN,
    REG_X_MAX,
    REG_BIN_COUNT,
    REG_WIDTH_RECIP
  } hwf_reg_t;

  typedef enum logic [1:0] {
    REQ_FILL_SAMPLE,
    REQ_FILL_BIN,
    REQ_READ_BIN,
    REQ_CLEAR
  } hwf_req_type_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNDER,
    ST_OVER,
    ST_BAD_INDEX
  } hwf_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_MOD,
    S_DONE
  } hwf_state_t;

  typedef struct packed {
    logic [X_W-1:0]     x_min;
    logic [X_W-1:0]     x_max;
    logic [CNT_W-1:0]   bin_count;
    logic [RECIP_W-1:0] width_recip;
  } hwf_cfg_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [X_W-1:0]             sample;
    logic signed [WEIGHT_W-1:0] weight;
    logic [BIDX_W-1:0]          bin_index;
  } hwf_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [BIDX_W-1:0]       bin_hit;
    logic signed [VAL_W-1:0] bin_value;
    logic [ENT_W-1:0]        bin_entries;
    logic signed [VAL_W-1:0] total_sum;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic [ENT_W-1:0]        underflow_count;
    logic [ENT_W-1:0]        overflow_count;
  } hwf_rsp_t;

endpackage

@@ hw/rtl/hwf_if.sv @@
interface hwf_req_if;
  logic             valid;
  logic             ready;
  hwf_pkg::hwf_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hwf_rsp_if;
  logic             valid;
  logic             ready;
  hwf_pkg::hwf_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/weighted_histogram_fill.sv @@
// channel  dir  transfer when          payload
// req      in   req.valid & req.ready  req_type, sample, weight, bin_index
// rsp      out  rsp.valid & rsp.ready  status, bin_hit, bin counters, totals
// apb      in   psel & penable & pwrite x_min, x_max, bin_count, width_recip
//
// a request runs through multiply, bin ram read, modify and write back
// a clear runs the same steps, then the ram is swept one bin per cycle
// after reset the same sweep runs before req.ready rises
// a new request is taken while the previous result still waits in rsp;
// the write back stalls until the rsp register is free
module weighted_histogram_fill #(
  parameter int BINS = hwf_pkg::DEFAULT_BINS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hwf_pkg::PADDR_W-1:0]  paddr,
  input  logic [hwf_pkg::APB_DW-1:0]   pwdata,
  output logic [hwf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  hwf_req_if.sink                      req,
  hwf_rsp_if.source                    rsp
);
  import hwf_pkg::*;

  localparam int IW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int NW = ($clog2(BINS + 1) > CNT_W) ? $clog2(BINS + 1) : CNT_W;

  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [ENT_W-1:0] sat_inc(input logic [ENT_W-1:0] c);
    return (c == ENT_MAX) ? c : c + ENT_W'(1);
  endfunction

  hwf_cfg_t   cfg;
  hwf_state_t state, state_next;

  logic [NW-1:0] bins_used;
  logic [IW-1:0] last_bin;

  hwf_req_type_t req_kind;
  hwf_status_t   status_in;
  logic          accept;

  hwf_req_type_t              op;
  logic [X_W-1:0]             sample_q;
  logic signed [VAL_W-1:0]    weight_q;
  logic [BIDX_W-1:0]          bi_q;
  hwf_status_t                status_q;
  logic                       have_bin;
  logic                       do_write;

  logic [IW-1:0]              sample_bin;
  logic [IW+BIDX_W-1:0]       bi_wide;
  logic [IW+BIDX_W-1:0]       hit_wide;
  logic [IW-1:0]              rd_addr;
  logic [IW-1:0]              idx_q;
  logic [IW-1:0]              clr_addr;
  logic                       clr_last;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [ENTRY_W-1:0]         ram_wdata;
  logic [ENTRY_W-1:0]         rd_data;
  logic signed [VAL_W-1:0]    cur_val;
  logic [ENT_W-1:0]           cur_cnt;
  logic signed [VAL_W-1:0]    vnew;
  logic [ENT_W-1:0]           cnew;

  logic signed [VAL_W-1:0]    running_sum, sum_next;
  logic signed [VAL_W-1:0]    min_seen, min_next;
  logic signed [VAL_W-1:0]    max_seen, max_next;
  logic [ENT_W-1:0]           under_count, under_next;
  logic [ENT_W-1:0]           over_count, over_next;

  logic                       out_valid;
  hwf_rsp_t                   out_data;
  logic                       out_free;
  logic                       finish;

  hwf_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.bin_count == '0) begin
      bins_used = NW'(1);
    end else if (NW'(cfg.bin_count) > NW'(BINS)) begin
      bins_used = NW'(BINS);
    end else begin
      bins_used = NW'(cfg.bin_count);
    end
    last_bin = IW'(bins_used - NW'(1));
  end

  // request classification at transfer
  assign req_kind  = hwf_req_type_t'(req.data.req_type);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    unique case (req_kind)
      REQ_FILL_SAMPLE: begin
        if (req.data.sample < cfg.x_min) begin
          status_in = ST_UNDER;
        end else if (req.data.sample >= cfg.x_max) begin
          status_in = ST_OVER;
        end else begin
          status_in = ST_OK;
        end
      end
      REQ_FILL_BIN, REQ_READ_BIN: begin
        status_in = (NW'(req.data.bin_index) >= bins_used) ? ST_BAD_INDEX : ST_OK;
      end
      REQ_CLEAR: status_in = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req_kind;
      sample_q <= req.data.sample;
      weight_q <= {{(VAL_W-WEIGHT_W){req.data.weight[WEIGHT_W-1]}}, req.data.weight};
      bi_q     <= req.data.bin_index;
      status_q <= status_in;
      have_bin <= (req_kind != REQ_CLEAR) && (status_in == ST_OK);
      do_write <= (req_kind != REQ_CLEAR) && (req_kind != REQ_READ_BIN) &&
                  (status_in == ST_OK);
    end
  end

  hwf_binner #(.BINS(BINS)) u_binner (
    .clk      (clk),
    .mul_en   (state == S_MUL),
    .sample   (sample_q),
    .cfg      (cfg),
    .last_bin (last_bin),
    .idx      (sample_bin)
  );

  assign bi_wide = {{IW{1'b0}}, bi_q};
  assign rd_addr = (op == REQ_FILL_SAMPLE) ? sample_bin : bi_wide[IW-1:0];

  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      idx_q <= rd_addr;
    end
  end

  // bin ram: sweep writes zero, write back stores the modified entry
  assign clr_last = (clr_addr == IW'(BINS - 1));
  assign out_free = !out_valid || rsp.ready;
  assign finish   = (state == S_DONE) && out_free;

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = finish && do_write;
      ram_waddr = idx_q;
      ram_wdata = {cnew, vnew};
    end
  end

  hwf_bin_ram #(.DEPTH(BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_ADDR),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cur_val = rd_data[VAL_W-1:0];
  assign cur_cnt = rd_data[ENTRY_W-1:VAL_W];

  always_ff @(posedge clk) begin
    if (state == S_MOD) begin
      vnew <= do_write ? sat_add(cur_val, weight_q) : cur_val;
      cnew <= do_write ? sat_inc(cur_cnt) : cur_cnt;
    end
  end

  always_comb begin
    sum_next   = running_sum;
    min_next   = min_seen;
    max_next   = max_seen;
    under_next = under_count;
    over_next  = over_count;
    if (do_write) begin
      sum_next = sat_add(running_sum, weight_q);
      if (vnew > max_seen) begin
        max_next = vnew;
      end
      if (vnew < min_seen) begin
        min_next = vnew;
      end
    end
    if (status_q == ST_UNDER) begin
      under_next = sat_inc(under_count);
    end
    if (status_q == ST_OVER) begin
      over_next = sat_inc(over_count);
    end
    if (op == REQ_CLEAR) begin
      sum_next   = '0;
      min_next   = '0;
      max_next   = '0;
      under_next = '0;
      over_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      min_seen    <= '0;
      max_seen    <= '0;
      under_count <= '0;
      over_count  <= '0;
    end else if (finish) begin
      running_sum <= sum_next;
      min_seen    <= min_next;
      max_seen    <= max_next;
      under_count <= under_next;
      over_count  <= over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_last ? '0 : clr_addr + IW'(1);
    end
  end

  // result register
  assign hit_wide = {{BIDX_W{1'b0}}, idx_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.status          <= status_q;
      out_data.bin_hit         <= have_bin ? hit_wide[BIDX_W-1:0] : '0;
      out_data.bin_value       <= have_bin ? vnew : '0;
      out_data.bin_entries     <= have_bin ? cnew : '0;
      out_data.total_sum       <= sum_next;
      out_data.min_value       <= min_next;
      out_data.max_value       <= max_next;
      out_data.underflow_count <= under_next;
      out_data.overflow_count  <= over_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_ADDR;
      S_ADDR: state_next = S_MOD;
      S_MOD:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = (op == REQ_CLEAR) ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/hwf_apb_regs.sv @@
module hwf_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hwf_pkg::PADDR_W-1:0]  paddr,
  input  logic [hwf_pkg::APB_DW-1:0]   pwdata,
  output logic [hwf_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output hwf_pkg::hwf_cfg_t            cfg
);
  import hwf_pkg::*;

  hwf_reg_t sel;
  logic     wr;

  assign sel    = hwf_reg_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min       <= X_MIN_RST;
      cfg.x_max       <= X_MAX_RST;
      cfg.bin_count   <= BIN_COUNT_RST;
      cfg.width_recip <= WIDTH_RECIP_RST;
    end else if (wr) begin
      unique case (sel)
        REG_X_MIN:       cfg.x_min       <= pwdata[X_W-1:0];
        REG_X_MAX:       cfg.x_max       <= pwdata[X_W-1:0];
        REG_BIN_COUNT:   cfg.bin_count   <= pwdata[CNT_W-1:0];
        REG_WIDTH_RECIP: cfg.width_recip <= pwdata[RECIP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_X_MIN:       prdata = APB_DW'(cfg.x_min);
      REG_X_MAX:       prdata = APB_DW'(cfg.x_max);
      REG_BIN_COUNT:   prdata = APB_DW'(cfg.bin_count);
      REG_WIDTH_RECIP: prdata = APB_DW'(cfg.width_recip);
    endcase
  end

endmodule

@@ hw/rtl/hwf_binner.sv @@
module hwf_binner #(
  parameter int  BINS = hwf_pkg::DEFAULT_BINS,
  localparam int IW   = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  logic                      clk,
  input  logic                      mul_en,
  input  logic [hwf_pkg::X_W-1:0]   sample,
  input  hwf_pkg::hwf_cfg_t         cfg,
  input  logic [IW-1:0]             last_bin,
  output logic [IW-1:0]             idx
);
  import hwf_pkg::*;

  logic [X_W-1:0]    offset;
  logic [PROD_W-1:0] product;
  logic [BIN_W-1:0]  raw_bin;

  assign offset = sample - cfg.x_min;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      product <= PROD_W'(offset) * PROD_W'(cfg.width_recip);
    end
  end

  assign raw_bin = product[PROD_W-1:FRAC_W];

  always_comb begin
    if (raw_bin > BIN_W'(last_bin)) begin
      idx = last_bin;
    end else begin
      idx = raw_bin[IW-1:0];
    end
  end

endmodule

@@ hw/rtl/hwf_bin_ram.sv @@
module hwf_bin_ram #(
  parameter int  DEPTH = hwf_pkg::DEFAULT_BINS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [hwf_pkg::ENTRY_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [hwf_pkg::ENTRY_W-1:0]   rdata
);
  import hwf_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ dv/tb_weighted_histogram_fill.sv @@
module tb_weighted_histogram_fill;
  import hwf_pkg::*;

  localparam int BINS        = DEFAULT_BINS;
  localparam int SETTLE      = BINS + 20;
  localparam int CYCLE_LIMIT = 400_000;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  hwf_req_if req_ch ();
  hwf_rsp_if rsp_ch ();

  weighted_histogram_fill #(.BINS(BINS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow of the histogram stores and registers
  longint          hist_val [BINS];
  int unsigned     hist_ent [BINS];
  longint          hist_sum;
  longint          hist_min;
  longint          hist_max;
  int unsigned     hist_under;
  int unsigned     hist_over;
  logic [X_W-1:0]     cfg_x_min   = X_MIN_RST;
  logic [X_W-1:0]     cfg_x_max   = X_MAX_RST;
  logic [CNT_W-1:0]   cfg_bins    = BIN_COUNT_RST;
  logic [RECIP_W-1:0] cfg_recip   = WIDTH_RECIP_RST;

  hwf_rsp_t    pending_rsp [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;

  function automatic longint sat_add48(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic int unsigned sat_inc32(int unsigned c);
    return (c == 32'hFFFF_FFFF) ? c : c + 1;
  endfunction

  function automatic int unsigned bins_active();
    int unsigned n;
    n = cfg_bins;
    if (n == 0) n = 1;
    if (n > BINS) n = BINS;
    return n;
  endfunction

  function automatic void add_weight(int unsigned idx, longint w);
    hist_val[idx] = sat_add48(hist_val[idx], w);
    hist_ent[idx] = sat_inc32(hist_ent[idx]);
    hist_sum = sat_add48(hist_sum, w);
    if (hist_val[idx] > hist_max) hist_max = hist_val[idx];
    if (hist_val[idx] < hist_min) hist_min = hist_val[idx];
  endfunction

  function automatic void clear_stores();
    foreach (hist_val[i]) begin
      hist_val[i] = 0;
      hist_ent[i] = 0;
    end
    hist_sum = 0;
    hist_min = 0;
    hist_max = 0;
    hist_under = 0;
    hist_over = 0;
  endfunction

  function automatic hwf_rsp_t histo_predict(hwf_req_t r);
    hwf_rsp_t e;
    int unsigned n;
    int unsigned d;
    int unsigned idx;
    longint unsigned b;
    longint w;
    bit hit;
    e = '0;
    e.status = ST_OK;
    n = bins_active();
    w = longint'($signed(r.weight));
    hit = 1'b0;
    idx = 0;
    case (hwf_req_type_t'(r.req_type))
      REQ_FILL_SAMPLE: begin
        if (r.sample < cfg_x_min) begin
          e.status = ST_UNDER;
          hist_under = sat_inc32(hist_under);
        end else if (r.sample >= cfg_x_max) begin
          e.status = ST_OVER;
          hist_over = sat_inc32(hist_over);
        end else begin
          d = r.sample - cfg_x_min;
          b = (longint'(d) * longint'(cfg_recip)) >> FRAC_W;
          if (b > n - 1) b = n - 1;
          idx = b;
          add_weight(idx, w);
          hit = 1'b1;
        end
      end
      REQ_FILL_BIN, REQ_READ_BIN: begin
        if (r.bin_index >= n) begin
          e.status = ST_BAD_INDEX;
        end else begin
          idx = r.bin_index;
          if (r.req_type == REQ_FILL_BIN) add_weight(idx, w);
          hit = 1'b1;
        end
      end
      default: clear_stores();
    endcase
    if (hit) begin
      e.bin_hit     = idx[BIDX_W-1:0];
      e.bin_value   = hist_val[idx][VAL_W-1:0];
      e.bin_entries = hist_ent[idx];
    end
    e.total_sum       = hist_sum[VAL_W-1:0];
    e.min_value       = hist_min[VAL_W-1:0];
    e.max_value       = hist_max[VAL_W-1:0];
    e.underflow_count = hist_under;
    e.overflow_count  = hist_over;
    return e;
  endfunction

  function automatic hwf_req_t mk_req(hwf_req_type_t t, int unsigned s, int w, int unsigned idx);
    hwf_req_t r;
    r.req_type  = t;
    r.sample    = s[X_W-1:0];
    r.weight    = w[WEIGHT_W-1:0];
    r.bin_index = idx[BIDX_W-1:0];
    return r;
  endfunction

  function automatic hwf_req_t rand_req();
    hwf_req_t r;
    int unsigned pick;
    int unsigned n;
    int ws;
    n = bins_active();
    pick = $urandom_range(99);
    if (pick < 1) r.req_type = REQ_CLEAR;
    else if (pick < 46) r.req_type = REQ_FILL_SAMPLE;
    else if (pick < 72) r.req_type = REQ_FILL_BIN;
    else r.req_type = REQ_READ_BIN;

    pick = $urandom_range(99);
    if (cfg_x_max > cfg_x_min && pick < 80) r.sample = $urandom_range(cfg_x_max - 1, cfg_x_min);
    else if (pick < 85) r.sample = cfg_x_min - 1;
    else if (pick < 90) r.sample = cfg_x_max;
    else r.sample = $urandom_range(16'hFFFF);

    pick = $urandom_range(99);
    ws = int'($urandom_range(8)) - 4;
    if (pick < 15) r.weight = 16'sd1;
    else if (pick < 85) r.weight = ws[WEIGHT_W-1:0];
    else r.weight = $urandom_range(16'hFFFF);

    if ($urandom_range(99) < 80) r.bin_index = $urandom_range(n - 1);
    else r.bin_index = $urandom_range(10'h3FF);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    hwf_rsp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual %0h", $time, rsp_ch.data);
      end else begin
        exp_r = pending_rsp.pop_front();
        check_field("status", exp_r.status, rsp_ch.data.status);
        check_field("bin_hit", exp_r.bin_hit, rsp_ch.data.bin_hit);
        check_field("bin_value", exp_r.bin_value, rsp_ch.data.bin_value);
        check_field("bin_entries", exp_r.bin_entries, rsp_ch.data.bin_entries);
        check_field("total_sum", exp_r.total_sum, rsp_ch.data.total_sum);
        check_field("min_value", exp_r.min_value, rsp_ch.data.min_value);
        check_field("max_value", exp_r.max_value, rsp_ch.data.max_value);
        check_field("underflow_count", exp_r.underflow_count, rsp_ch.data.underflow_count);
        check_field("overflow_count", exp_r.overflow_count, rsp_ch.data.overflow_count);
      end
    end
  end

  // result receiver with random stalls and long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_req(hwf_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.insert(pending_rsp.size(), histo_predict(r));
    @(negedge clk);
  endtask

  // stop sending, wait for all results and for the block to go idle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(hwf_reg_t a, logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {a, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (a)
      REG_X_MIN:     cfg_x_min = v[X_W-1:0];
      REG_X_MAX:     cfg_x_max = v[X_W-1:0];
      REG_BIN_COUNT: cfg_bins  = v[CNT_W-1:0];
      default:       cfg_recip = v[RECIP_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [X_W-1:0] xmin, logic [X_W-1:0] xmax,
                            logic [CNT_W-1:0] cnt, logic [RECIP_W-1:0] recip);
    apb_write(REG_X_MIN, APB_DW'(xmin));
    apb_write(REG_X_MAX, APB_DW'(xmax));
    apb_write(REG_BIN_COUNT, APB_DW'(cnt));
    apb_write(REG_WIDTH_RECIP, APB_DW'(recip));
  endtask

  task automatic rand_config();
    int unsigned xmin;
    int unsigned xmax;
    int unsigned cnt;
    longint unsigned recip;
    xmin  = $urandom_range(30000);
    xmax  = $urandom_range(65535, xmin + 1);
    cnt   = $urandom_range(BINS, 1);
    recip = (longint'(cnt) << FRAC_W) / (xmax - xmin) + $urandom_range(3);
    if (recip > 24'hFFFFFF) recip = 24'hFFFFFF;
    set_config(xmin, xmax, cnt, recip);
  endtask

  task automatic set_idle(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  task automatic run_random(int count);
    repeat (count) send_req(rand_req());
    drain();
  endtask

  task automatic test_full_axis();
    set_config(X_MIN_RST, X_MAX_RST, BIN_COUNT_RST, WIDTH_RECIP_RST);
    send_req(mk_req(REQ_FILL_SAMPLE, 0, 1, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 65534, 32767, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 65535, 1, 0));
    send_req(mk_req(REQ_FILL_BIN, 0, -32768, 1023));
    send_req(mk_req(REQ_FILL_BIN, 65535, 0, 0));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 1023));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 512));
    drain();
  endtask

  task automatic test_narrow_axis();
    // the last in-range sample lands past the last bin and is clamped
    set_config(1000, 2000, 10, 700);
    send_req(mk_req(REQ_FILL_SAMPLE, 999, 3, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 1000, 5, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 1999, -7, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 2000, 2, 0));
    send_req(mk_req(REQ_FILL_BIN, 0, 4, 10));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 1023));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 9));
    drain();
  endtask

  task automatic test_edge_configs();
    // upper edge below lower edge
    set_config(16'hFFFF, 16'h0000, 11'h7FF, 24'hFFFFFF);
    send_req(mk_req(REQ_FILL_SAMPLE, 65534, 1, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 65535, 1, 0));
    send_req(mk_req(REQ_FILL_SAMPLE, 0, 1, 0));
    send_req(mk_req(REQ_FILL_BIN, 0, 9, 1023));
    drain();
    // zero reciprocal width
    set_config(0, 65535, 11'h7FF, 0);
    send_req(mk_req(REQ_FILL_SAMPLE, 65534, 11, 0));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 0));
    drain();
    // zero bin count acts as one bin
    set_config(0, 65535, 0, 24'hFFFFFF);
    send_req(mk_req(REQ_FILL_SAMPLE, 1, -2, 0));
    send_req(mk_req(REQ_FILL_BIN, 0, 1, 1));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 0));
    drain();
  endtask

  task automatic test_clear();
    set_config(X_MIN_RST, X_MAX_RST, BIN_COUNT_RST, WIDTH_RECIP_RST);
    send_req(mk_req(REQ_CLEAR, 65535, -1, 1023));
    send_req(mk_req(REQ_READ_BIN, 0, 0, 1023));
    send_req(mk_req(REQ_FILL_SAMPLE, 3000, 1, 0));
    send_req(mk_req(REQ_CLEAR, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      if (p < 2) set_idle(13, 55);
      else if (p < 4) set_idle(55, 13);
      else set_idle(0, 0);
      case (p)
        0: set_config(X_MIN_RST, X_MAX_RST, BIN_COUNT_RST, WIDTH_RECIP_RST);
        2: set_config($urandom_range(2000), $urandom_range(65535, 30000), 1, 24'hFFFFFF);
        4: set_config(0, 65535, 11'h7FF, $urandom_range(24'hFFFFFF));
        default: rand_config();
      endcase
      run_random(270);
    end
  endtask

  task automatic test_output_stall();
    set_idle(0, 0);
    set_config(X_MIN_RST, X_MAX_RST, BIN_COUNT_RST, WIDTH_RECIP_RST);
    hold_left = 400;
    run_random(150);
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    clear_stores();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // wait out the sweep that follows reset
    repeat (SETTLE) @(negedge clk);
    set_idle(13, 55);
    test_full_axis();
    test_narrow_axis();
    test_edge_configs();
    test_clear();
    test_random_traffic();
    test_output_stall();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hwf_pkg.sv
hw/rtl/hwf_if.sv
hw/rtl/hwf_apb_regs.sv
hw/rtl/hwf_binner.sv
hw/rtl/hwf_bin_ram.sv
hw/rtl/weighted_histogram_fill.sv
dv/tb_weighted_histogram_fill.sv
